@@ rtl/core/mrlb_pkg.sv @@
// Shared types, codes and the overflow notice text of the message ring log buffer.
`timescale 1ns / 1ps
package mrlb_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_STORED   = 3'd1,
        ST_NOTICE   = 3'd2,
        ST_REJECTED = 3'd3,
        ST_NO_MSG   = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    // Command passed from the front end to the executor
    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_cmd;

    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam int         NOTICE_LEN = 29;
    localparam int         POP_WINDOW = 64;
    localparam int         LEN_W      = 7;   // staging length, 0..64
    localparam int         IDX_W      = 6;   // pop byte index, 0..63
    localparam int         Q_DEPTH    = 4;
    localparam int         Q_AW       = 2;

    // Overflow notice ROM: "MAX LOG STRING SIZE EXCEEDED\n"
    function automatic logic [7:0] notice_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:  b = 8'h4D;  5'd1:  b = 8'h41;  5'd2:  b = 8'h58;  5'd3:  b = 8'h20;
            5'd4:  b = 8'h4C;  5'd5:  b = 8'h4F;  5'd6:  b = 8'h47;  5'd7:  b = 8'h20;
            5'd8:  b = 8'h53;  5'd9:  b = 8'h54;  5'd10: b = 8'h52;  5'd11: b = 8'h49;
            5'd12: b = 8'h4E;  5'd13: b = 8'h47;  5'd14: b = 8'h20;  5'd15: b = 8'h53;
            5'd16: b = 8'h49;  5'd17: b = 8'h5A;  5'd18: b = 8'h45;  5'd19: b = 8'h20;
            5'd20: b = 8'h45;  5'd21: b = 8'h58;  5'd22: b = 8'h43;  5'd23: b = 8'h45;
            5'd24: b = 8'h45;  5'd25: b = 8'h44;  5'd26: b = 8'h45;  5'd27: b = 8'h44;
            5'd28: b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/mrlb_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
interface mrlb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, kind, data_byte, last_byte, input ready);
    modport sink   (input valid, kind, data_byte, last_byte, output ready);
endinterface

interface mrlb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [2:0]  status;
    logic [31:0] error_count;

    modport source (output valid, out_byte, out_last, status, error_count, input ready);
    modport sink   (input valid, out_byte, out_last, status, error_count, output ready);
endinterface

@@ rtl/core/message_ring_log_buffer.sv @@
// Top level of the message ring log buffer: front end, command queue, executor.
`timescale 1ns / 1ps
// Push bytes are taken one per cycle while the executor is idle and staged
// straight into the ring RAM; the last byte commits the message and queues a
// status result, and an overlong message gets the 29-byte notice if it fits. A pop
// scans the ring through one RAM read port at one byte per cycle up to the
// first newline (at most 64 bytes), then reads the message again and gives one
// byte result per cycle while the output accepts. A clear and a pop with no
// newline stored go straight to their status result; a pop whose newline lies
// past the window first scans the whole window. A four-entry command queue
// lets the input side keep accepting items while the executor is busy or the
// output stalls.
module message_ring_log_buffer #(
    parameter int BUFFER_BYTES = 1024,
    parameter int MAX_MSG      = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mrlb_in_if.sink      i_in,
    mrlb_out_if.source   o_out
);
    logic            q_push, q_full, q_pop, q_valid;
    mrlb_pkg::t_cmd  q_in, q_out;

    mrlb_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (q_push),
        .o_cmd  (q_in)
    );

    mrlb_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    mrlb_exec #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_MSG      (MAX_MSG)
    ) u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    // Queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    // Executor only takes a command that is there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("executor took from empty queue");

    // Status results are single items, always marked last
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != mrlb_pkg::ST_BYTE) |-> o_out.out_last)
        else $error("status result without last marker");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");
endmodule

@@ rtl/core/mrlb_ram.sv @@
// Generic simple dual-port RAM with registered, enabled read.
`timescale 1ns / 1ps
module mrlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/mrlb_front.sv @@
// Front end: accepts input items, drops unknown kinds, queues commands.
`timescale 1ns / 1ps
module mrlb_front (
    mrlb_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output mrlb_pkg::t_cmd  o_cmd
);
    // Take an item whenever the queue has room; unknown kinds vanish here
    assign i_in.ready = !i_full;

    always_comb begin
        o_cmd.op        = mrlb_pkg::t_op'(i_in.kind);
        o_cmd.data_byte = i_in.data_byte;
        o_cmd.last_byte = i_in.last_byte;
        o_push          = 1'b0;
        unique case (i_in.kind)
            mrlb_pkg::OP_PUSH, mrlb_pkg::OP_POP, mrlb_pkg::OP_CLEAR: begin
                o_push = i_in.valid && !i_full;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end
endmodule

@@ rtl/core/mrlb_cmdq.sv @@
// Short command queue between the front end and the executor.
`timescale 1ns / 1ps
module mrlb_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mrlb_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mrlb_pkg::t_cmd  o_cmd
);
    mrlb_pkg::t_cmd              r_slot [mrlb_pkg::Q_DEPTH];
    logic [mrlb_pkg::Q_AW-1:0]   r_wr, r_rd;
    logic [mrlb_pkg::Q_AW:0]     r_cnt;
    logic                        push_ok, pop_ok;

    assign o_full  = (r_cnt == (mrlb_pkg::Q_AW+1)'(mrlb_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wr <= r_wr + 1'b1;
            if (pop_ok)  r_rd <= r_rd + 1'b1;
            if (push_ok && !pop_ok)      r_cnt <= r_cnt + 1'b1;
            else if (pop_ok && !push_ok) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

@@ rtl/core/mrlb_exec.sv @@
// Executor: ring pointers, staging, notice writes, pop scan and result output.
`timescale 1ns / 1ps
module mrlb_exec #(
    parameter int BUFFER_BYTES = 1024,
    parameter int MAX_MSG      = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mrlb_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    mrlb_out_if.source      o_out
);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = AW + 1;
    localparam logic [mrlb_pkg::LEN_W-1:0] LP_MAX = mrlb_pkg::LEN_W'(MAX_MSG);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NOTE = 5'b00010,
        S_SCAN = 5'b00100,
        S_EMIT = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] next_p(input logic [AW-1:0] p);
        return (p == AW'(BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    t_state                         r_st, n_st;
    logic [AW-1:0]                  r_wp, n_wp, r_rp, n_rp, r_sp, n_sp, r_ra, n_ra;
    logic                           r_full, n_full, r_rej, n_rej;
    logic [mrlb_pkg::LEN_W-1:0]     r_len, n_len, r_nls, n_nls, r_plen, n_plen;
    logic [mrlb_pkg::LEN_W-1:0]     r_win, n_win;
    logic [mrlb_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic [4:0]                     r_k, n_k;
    logic [CW-1:0]                  r_nlc, n_nlc;
    logic [31:0]                    r_fail, n_fail;
    mrlb_pkg::t_status              r_pend, n_pend;

    // Output register
    logic                           r_ov, n_ov, r_ol, n_ol;
    logic [7:0]                     r_ob, n_ob;
    mrlb_pkg::t_status              r_os, n_os;
    logic [31:0]                    r_oe, n_oe;

    // RAM ports
    logic                           we, re;
    logic [AW-1:0]                  waddr, raddr;
    logic [7:0]                     wdata, ram_q;

    // Datapath helpers
    logic [CW-1:0]                  cnt, free_b;
    logic                           adv, len_lt, wr_ok, is_nl;
    logic [mrlb_pkg::LEN_W-1:0]     idx_p1;

    mrlb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // Stored bytes and free space
    always_comb begin
        if (r_full)             cnt = CW'(BUFFER_BYTES);
        else if (r_wp >= r_rp)  cnt = CW'(r_wp) - CW'(r_rp);
        else                    cnt = CW'(BUFFER_BYTES) - CW'(r_rp) + CW'(r_wp);
        free_b = CW'(BUFFER_BYTES) - cnt;
    end

    assign adv    = !r_ov || o_out.ready;
    assign len_lt = (r_len < LP_MAX);
    assign wr_ok  = len_lt && !r_rej && (CW'(r_len) < free_b);
    assign is_nl  = (i_cmd.data_byte == mrlb_pkg::NEWLINE);
    assign idx_p1 = mrlb_pkg::LEN_W'(r_idx) + 1'b1;

    // Sequencer
    always_comb begin
        n_st = r_st;  n_wp = r_wp;  n_rp = r_rp;  n_sp = r_sp;  n_ra = r_ra;
        n_full = r_full;  n_rej = r_rej;  n_len = r_len;  n_nls = r_nls;
        n_plen = r_plen;  n_win = r_win;  n_idx = r_idx;  n_k = r_k;
        n_nlc = r_nlc;  n_fail = r_fail;  n_pend = r_pend;
        n_ov = r_ov && !o_out.ready;
        n_ob = r_ob;  n_ol = r_ol;  n_os = r_os;  n_oe = r_oe;
        o_pop = 1'b0;
        we = 1'b0;  waddr = r_sp;  wdata = i_cmd.data_byte;
        re = 1'b0;  raddr = r_ra;

        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        mrlb_pkg::OP_PUSH: begin
                            // Stage the byte past the write pointer
                            if (wr_ok) begin
                                we    = 1'b1;
                                n_sp  = next_p(r_sp);
                                n_nls = r_nls + mrlb_pkg::LEN_W'(is_nl);
                            end
                            if (len_lt) begin
                                n_len = r_len + 1'b1;
                                n_rej = r_rej || !wr_ok;
                            end
                            // Commit on the last byte
                            if (i_cmd.last_byte) begin
                                if (n_len >= LP_MAX) begin
                                    if (CW'(mrlb_pkg::NOTICE_LEN) <= free_b) begin
                                        n_k  = '0;
                                        n_st = S_NOTE;
                                    end else begin
                                        n_pend = mrlb_pkg::ST_REJECTED;
                                        n_sp   = r_wp;
                                        n_st   = S_RESP;
                                    end
                                end else if (!n_rej) begin
                                    n_nlc  = r_nlc + CW'(n_nls);
                                    n_wp   = n_sp;
                                    n_full = (n_sp == r_rp);
                                    n_pend = mrlb_pkg::ST_STORED;
                                    n_st   = S_RESP;
                                end else begin
                                    n_pend = mrlb_pkg::ST_REJECTED;
                                    n_sp   = r_wp;
                                    n_st   = S_RESP;
                                end
                                n_len = '0;
                                n_rej = 1'b0;
                                n_nls = '0;
                            end
                        end
                        mrlb_pkg::OP_POP: begin
                            if (r_nlc == '0) begin
                                n_fail = r_fail + 1'b1;
                                n_pend = mrlb_pkg::ST_NO_MSG;
                                n_st   = S_RESP;
                            end else begin
                                re    = 1'b1;
                                raddr = r_rp;
                                n_ra  = next_p(r_rp);
                                n_idx = '0;
                                n_win = (cnt < CW'(mrlb_pkg::POP_WINDOW)) ?
                                        mrlb_pkg::LEN_W'(cnt) :
                                        mrlb_pkg::LEN_W'(mrlb_pkg::POP_WINDOW);
                                n_st  = S_SCAN;
                            end
                        end
                        mrlb_pkg::OP_CLEAR: begin
                            n_wp   = '0;  n_rp  = '0;  n_sp  = '0;
                            n_full = 1'b0;  n_nlc = '0;
                            n_len  = '0;  n_rej = 1'b0;  n_nls = '0;
                            n_pend = mrlb_pkg::ST_CLEARED;
                            n_st   = S_RESP;
                        end
                        default: begin
                            n_st = S_IDLE;
                        end
                    endcase
                end
            end
            S_NOTE: begin
                // One notice byte per cycle over the staged area
                we    = 1'b1;
                waddr = r_wp;
                wdata = mrlb_pkg::notice_byte(r_k);
                n_wp  = next_p(r_wp);
                n_k   = r_k + 1'b1;
                if (r_k == 5'(mrlb_pkg::NOTICE_LEN - 1)) begin
                    n_nlc  = r_nlc + 1'b1;
                    n_full = (next_p(r_wp) == r_rp);
                    n_sp   = next_p(r_wp);
                    n_pend = mrlb_pkg::ST_NOTICE;
                    n_st   = S_RESP;
                end
            end
            S_SCAN: begin
                // ram_q holds byte r_idx of the window
                if (ram_q == mrlb_pkg::NEWLINE) begin
                    n_plen = idx_p1;
                    re     = 1'b1;
                    raddr  = r_rp;
                    n_ra   = next_p(r_rp);
                    n_idx  = '0;
                    n_st   = S_EMIT;
                end else if (idx_p1 == r_win) begin
                    n_fail = r_fail + 1'b1;
                    n_pend = mrlb_pkg::ST_NO_MSG;
                    n_st   = S_RESP;
                end else begin
                    re    = 1'b1;
                    n_ra  = next_p(r_ra);
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                // Read data holds while the output stalls
                if (adv) begin
                    n_ov = 1'b1;
                    n_ob = ram_q;
                    n_ol = (idx_p1 == r_plen);
                    n_os = mrlb_pkg::ST_BYTE;
                    n_oe = r_fail;
                    if (idx_p1 == r_plen) begin
                        n_rp   = r_ra;
                        n_full = 1'b0;
                        n_nlc  = r_nlc - 1'b1;
                        n_st   = S_IDLE;
                    end else begin
                        re    = 1'b1;
                        n_ra  = next_p(r_ra);
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (adv) begin
                    n_ov = 1'b1;
                    n_ob = '0;
                    n_ol = 1'b1;
                    n_os = r_pend;
                    n_oe = r_fail;
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_wp   <= '0;  r_rp  <= '0;  r_sp  <= '0;
            r_full <= 1'b0;  r_rej <= 1'b0;
            r_len  <= '0;  r_nls <= '0;  r_nlc <= '0;
            r_fail <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_wp   <= n_wp;  r_rp  <= n_rp;  r_sp  <= n_sp;
            r_full <= n_full;  r_rej <= n_rej;
            r_len  <= n_len;  r_nls <= n_nls;  r_nlc <= n_nlc;
            r_fail <= n_fail;
            r_ov   <= n_ov;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_ra   <= n_ra;
        r_plen <= n_plen;
        r_win  <= n_win;
        r_idx  <= n_idx;
        r_k    <= n_k;
        r_pend <= n_pend;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
        r_os   <= n_os;
        r_oe   <= n_oe;
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_byte    = r_ob;
    assign o_out.out_last    = r_ol;
    assign o_out.status      = r_os;
    assign o_out.error_count = r_oe;
endmodule

@@ bench/message_ring_log_buffer_tb.sv @@
// Self-checking testbench for the message ring log buffer: random push/pop/clear traffic.
`timescale 1ns / 1ps
module message_ring_log_buffer_tb;

    localparam int         RING_BYTES  = 1024;
    localparam int         MSG_MAX     = 64;
    localparam logic [1:0] KIND_UNUSED = 2'd3;   // kind with no meaning

    // One result item as seen on the output channel
    typedef struct {
        logic [7:0]        out_byte;
        logic              out_last;
        mrlb_pkg::t_status status;
        logic [31:0]       error_count;
    } t_result;

    // Scoreboard: own model of the ring and a queue of expected results
    class ring_scoreboard;
        logic [7:0]  ring_mem [RING_BYTES];
        int unsigned wr_ptr, rd_ptr, stage_ptr, stage_len, nl_count;
        bit          full, stage_bad;
        logic [31:0] failed_pops;
        t_result     pending[$];
        int          mismatches;

        function new();
            wr_ptr = 0; rd_ptr = 0; stage_ptr = 0; stage_len = 0; nl_count = 0;
            full = 0; stage_bad = 0; failed_pops = 0; mismatches = 0;
            foreach (ring_mem[i]) ring_mem[i] = 8'h00;
        endfunction

        function int unsigned stored_bytes();
            if (full) return RING_BYTES;
            if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
            return RING_BYTES - rd_ptr + wr_ptr;
        endfunction

        function void add(logic [7:0] b, logic l, mrlb_pkg::t_status s);
            t_result r;
            r.out_byte = b; r.out_last = l; r.status = s; r.error_count = failed_pops;
            pending.push_back(r);
        endfunction

        // Work out the results of one accepted input item
        function void note_input(logic [1:0] kind, logic [7:0] data, logic last);
            int unsigned free_b, p, len;
            mrlb_pkg::t_status st;
            bit found;
            case (kind)
                mrlb_pkg::OP_PUSH: begin
                    free_b = RING_BYTES - stored_bytes();
                    if (stage_len < MSG_MAX) begin
                        if (!stage_bad && stage_len < free_b) begin
                            ring_mem[stage_ptr] = data;
                            stage_ptr = (stage_ptr + 1) % RING_BYTES;
                        end else begin
                            stage_bad = 1;
                        end
                        stage_len++;
                    end
                    if (last) begin
                        if (stage_len >= MSG_MAX) begin
                            if (mrlb_pkg::NOTICE_LEN <= free_b) begin
                                for (int i = 0; i < mrlb_pkg::NOTICE_LEN; i++) begin
                                    ring_mem[wr_ptr] = notice_text(i);
                                    wr_ptr = (wr_ptr + 1) % RING_BYTES;
                                end
                                nl_count++;
                                st = mrlb_pkg::ST_NOTICE;
                            end else begin
                                st = mrlb_pkg::ST_REJECTED;
                            end
                        end else if (!stage_bad) begin
                            p = wr_ptr;
                            for (int i = 0; i < stage_len; i++) begin
                                if (ring_mem[p] == mrlb_pkg::NEWLINE) nl_count++;
                                p = (p + 1) % RING_BYTES;
                            end
                            wr_ptr = stage_ptr;
                            st = mrlb_pkg::ST_STORED;
                        end else begin
                            st = mrlb_pkg::ST_REJECTED;
                        end
                        if (st != mrlb_pkg::ST_REJECTED) full = (wr_ptr == rd_ptr);
                        stage_ptr = wr_ptr; stage_len = 0; stage_bad = 0;
                        add(8'h00, 1'b1, st);
                    end
                end
                mrlb_pkg::OP_POP: begin
                    found = 0; len = 0;
                    if (nl_count != 0) begin
                        p = rd_ptr;
                        for (int i = 0; i < mrlb_pkg::POP_WINDOW && i < stored_bytes();
                             i++) begin
                            if (!found && ring_mem[p] == mrlb_pkg::NEWLINE) begin
                                len = i + 1; found = 1;
                            end
                            p = (p + 1) % RING_BYTES;
                        end
                    end
                    if (!found) begin
                        failed_pops++;
                        add(8'h00, 1'b1, mrlb_pkg::ST_NO_MSG);
                    end else begin
                        for (int i = 0; i < len; i++) begin
                            add(ring_mem[rd_ptr], i + 1 == len, mrlb_pkg::ST_BYTE);
                            rd_ptr = (rd_ptr + 1) % RING_BYTES;
                        end
                        full = 0;
                        nl_count--;
                    end
                end
                mrlb_pkg::OP_CLEAR: begin
                    foreach (ring_mem[i]) ring_mem[i] = 8'h00;
                    wr_ptr = 0; rd_ptr = 0; full = 0; nl_count = 0;
                    stage_ptr = 0; stage_len = 0; stage_bad = 0;
                    add(8'h00, 1'b1, mrlb_pkg::ST_CLEARED);
                end
                default: ;
            endcase
        endfunction

        // Independent copy of the notice text
        function logic [7:0] notice_text(int i);
            string s;
            s = "MAX LOG STRING SIZE EXCEEDED\n";
            return s[i];
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            mismatches++;
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(t_result r);
            t_result e;
            if (pending.size() == 0) begin
                report("unexpected result", 32'(r.status), 0);
                return;
            end
            e = pending.pop_front();
            if (r.out_byte !== e.out_byte) report("out_byte", 32'(r.out_byte), 32'(e.out_byte));
            if (r.out_last !== e.out_last) report("out_last", 32'(r.out_last), 32'(e.out_last));
            if (r.status !== e.status) report("status", 32'(r.status), 32'(e.status));
            if (r.error_count !== e.error_count)
                report("error_count", r.error_count, e.error_count);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    mrlb_in_if  in_ch();
    mrlb_out_if out_ch();
    ring_scoreboard sb = new();
    int  hold_off = 0;   // forced long receiver stall, counted in cycles
    bit  done = 0;

    message_ring_log_buffer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0; in_ch.kind = mrlb_pkg::OP_PUSH; in_ch.data_byte = 0;
        in_ch.last_byte = 0;
        out_ch.ready = 0;
    end

    // Often no gap, often a short one, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and wait until it is accepted
    task automatic send_item(logic [1:0] kind, logic [7:0] data, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1; in_ch.kind <= kind; in_ch.data_byte <= data;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(kind, data, last);
    endtask

    task automatic send_msg(int len, bit nl_end);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == mrlb_pkg::NEWLINE && $urandom_range(0, 3) != 0) b = 8'h41;
            if (i == len - 1 && nl_end) b = mrlb_pkg::NEWLINE;
            send_item(mrlb_pkg::OP_PUSH, b, i == len - 1);
        end
    endtask

    // Receiver: random stalls plus a long forced hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) < 70) ||
                            (($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1) && done;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_result r;
            r.out_byte = out_ch.out_byte; r.out_last = out_ch.out_last;
            r.status = mrlb_pkg::t_status'(out_ch.status);
            r.error_count = out_ch.error_count;
            sb.check_result(r);
        end
    end

    initial begin
        int k, n, len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: empty pop, extremes, unknown kind, overlong, no newline, clears
        send_item(mrlb_pkg::OP_POP, 8'hFF, 1);
        send_item(KIND_UNUSED, 8'hFF, 1);
        send_item(mrlb_pkg::OP_PUSH, mrlb_pkg::NEWLINE, 1);
        send_item(mrlb_pkg::OP_PUSH, 8'hFF, 0);
        send_item(mrlb_pkg::OP_PUSH, 8'h00, 0);
        send_item(mrlb_pkg::OP_PUSH, mrlb_pkg::NEWLINE, 1);
        send_item(mrlb_pkg::OP_POP, 8'h00, 0);
        send_item(mrlb_pkg::OP_PUSH, 8'h55, 1);       // no newline: joins the next message
        send_msg(3, 1);
        send_item(mrlb_pkg::OP_POP, 8'hAA, 1);
        send_item(mrlb_pkg::OP_POP, 8'h00, 0);
        send_msg(70, 1);                               // overlong -> notice
        send_item(mrlb_pkg::OP_POP, 8'h00, 0);
        send_item(mrlb_pkg::OP_PUSH, 8'h31, 0);
        send_item(mrlb_pkg::OP_CLEAR, 8'h12, 1);      // clear during a push
        send_item(mrlb_pkg::OP_PUSH, mrlb_pkg::NEWLINE, 1);
        send_item(mrlb_pkg::OP_POP, 8'h00, 0);
        // Receiver stalls long enough for the queue to fill and the input to back up
        hold_off = 300;
        for (int i = 0; i < 6; i++) send_msg($urandom_range(8, 16), 1);
        send_item(mrlb_pkg::OP_POP, 8'h00, 0);
        send_item(mrlb_pkg::OP_CLEAR, 8'h00, 0);
        // Newline past the pop window: the scan runs out
        for (int i = 0; i < 2; i++) send_msg(35, 0);
        send_msg(2, 1);
        send_item(mrlb_pkg::OP_POP, 8'h00, 0);
        send_item(mrlb_pkg::OP_CLEAR, 8'h00, 0);
        // Random part
        n = 0;
        while (n < 185) begin
            k = $urandom_range(0, 99);
            if (k < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 75)
                      : $urandom_range(1, 12);
                send_msg(len, $urandom_range(0, 7) != 0);
                n += len;
            end else if (k < 88) begin
                send_item(mrlb_pkg::OP_POP, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                n++;
            end else if (k < 92) begin
                send_item(mrlb_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                n++;
            end else if (k < 95) begin
                send_item(KIND_UNUSED, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                n++;
            end else begin
                send_item(mrlb_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                n++;
            end
        end
        in_ch.valid <= 0;
        done = 1;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/mrlb_pkg.sv
rtl/core/mrlb_if.sv
rtl/core/mrlb_ram.sv
rtl/core/mrlb_front.sv
rtl/core/mrlb_cmdq.sv
rtl/core/mrlb_exec.sv
rtl/core/message_ring_log_buffer.sv
bench/message_ring_log_buffer_tb.sv
